[rtl/astm_frame_receiver_macros.svh]
// Assertion macros used by the frame receiver top module (astm_frame_receiver).
`ifndef ASTM_FRAME_RECEIVER_MACROS_SVH
`define ASTM_FRAME_RECEIVER_MACROS_SVH

// Checked on every clk edge outside reset.
`define AFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clk edge, reset included.
`define AFR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/afr_pkg.sv]
// Package: character codes, phase/event/reply codes, shared types and a hex-digit helper of the frame receiver.
`default_nettype none
package afr_pkg;

	localparam logic [7:0] C_STX = 8'h02;
	localparam logic [7:0] C_ETX = 8'h03;
	localparam logic [7:0] C_EOT = 8'h04;
	localparam logic [7:0] C_ENQ = 8'h05;
	localparam logic [7:0] C_ACK = 8'h06;
	localparam logic [7:0] C_LF  = 8'h0A;
	localparam logic [7:0] C_NAK = 8'h15;
	localparam logic [7:0] C_ETB = 8'h17;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_BODY = 3'd1;
	localparam logic [2:0] PH_CK1  = 3'd2;
	localparam logic [2:0] PH_CK2  = 3'd3;
	localparam logic [2:0] PH_WOK  = 3'd4;
	localparam logic [2:0] PH_WBAD = 3'd5;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_ENQ  = 3'd1;
	localparam logic [2:0] EV_EOT  = 3'd2;
	localparam logic [2:0] EV_ACK  = 3'd3;
	localparam logic [2:0] EV_NAK  = 3'd4;
	localparam logic [2:0] EV_GOOD = 3'd5;
	localparam logic [2:0] EV_BAD  = 3'd6;
	localparam logic [2:0] EV_FMT  = 3'd7;

	localparam logic [1:0] RP_NONE = 2'd0;
	localparam logic [1:0] RP_ACK  = 2'd1;
	localparam logic [1:0] RP_NAK  = 2'd2;

	typedef struct packed {
		logic [2:0] phase;
		logic [7:0] running_sum;
		logic [7:0] first_hex_char;
		logic       stray_seen;
	} afr_state_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [1:0] reply;
		logic [7:0] frame_sum;
	} afr_res_t;

	// upper-case ASCII hex digit of a nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		if (nib < 4'd10) begin
			hex_digit = 8'h30 + {4'd0, nib};
		end else begin
			hex_digit = 8'h37 + {4'd0, nib};
		end
	endfunction

endpackage
`default_nettype wire

[rtl/astm_frame_receiver.sv]
// A result word is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_stall is low; the only loop is the registered state update.
// The result register lets a new byte in whenever the pending result is taken or absent.
// Reset (arst_n low, asynchronous) returns to idle with zero sum, no stray mark,
// and no result pending.
`default_nettype none
`include "astm_frame_receiver_macros.svh"
module astm_frame_receiver
	import afr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] event_res,
	output logic [1:0] reply,
	output logic [7:0] frame_sum
);

	afr_state_t state_q;
	afr_state_t state_nxt;
	afr_res_t   res_nxt;
	afr_res_t   res_q;
	logic       out_valid_q;
	logic       in_acc;
	logic       frame_end;

	assign in_stall = out_valid_q && out_stall;
	assign in_acc = in_valid && !in_stall;
	assign frame_end = (res_nxt.event_res == EV_GOOD) || (res_nxt.event_res == EV_BAD) ||
		(res_nxt.event_res == EV_FMT);

	afr_step u_step (
		.cur     (state_q),
		.rx_byte (rx_byte),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, running_sum: '0, first_hex_char: '0,
				stray_seen: 1'b0};
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = res_q.event_res;
	assign reply     = res_q.reply;
	assign frame_sum = res_q.frame_sum;

	`AFR_ASSERT(a_phase_legal, (state_q.phase <= PH_WBAD), "phase left its legal range")
	`AFR_ASSERT(a_sum_only_on_end, (out_valid && frame_sum != 8'd0) |-> (event_res == EV_GOOD || event_res == EV_BAD || event_res == EV_FMT), "frame sum shown without frame end")
	`AFR_ASSERT(a_ack_reply, (out_valid && reply == RP_ACK) |-> (event_res == EV_ENQ || event_res == EV_GOOD), "ACK reply on wrong event")
	`AFR_ASSERT(a_end_to_idle, (in_acc && frame_end) |=> (state_q.phase == PH_IDLE && !state_q.stray_seen), "frame end did not return to clean idle")
	`AFR_ASSERT(a_stall_blocks_input, (out_valid && out_stall) |-> in_stall, "input taken over a held result")

endmodule
`default_nettype wire

[rtl/afr_step.sv]
// Combinational per-word step: next receiver state and the result for one received byte.
`default_nettype none
module afr_step
	import afr_pkg::*;
(
	input  afr_state_t cur,
	input  logic [7:0] rx_byte,
	output afr_state_t nxt,
	output afr_res_t   res
);

	logic finish;
	logic good;
	logic hi_ok;
	logic lo_ok;
	logic in_frame;

	assign hi_ok = cur.first_hex_char == hex_digit(cur.running_sum[7:4]);
	assign lo_ok = rx_byte == hex_digit(cur.running_sum[3:0]);
	assign in_frame = (cur.phase == PH_BODY) || (cur.phase == PH_CK1) ||
		(cur.phase == PH_CK2) || (cur.phase == PH_WOK) || (cur.phase == PH_WBAD);

	always_comb begin
		nxt = cur;
		res = '0;
		finish = 1'b0;
		good = 1'b0;
		if (!in_frame) begin
			nxt.phase = PH_IDLE;
			unique case (rx_byte)
				C_STX: begin
					nxt.running_sum = '0;
					nxt.phase = PH_BODY;
				end
				C_ENQ: begin
					res.event_res = EV_ENQ;
					res.reply = RP_ACK;
					nxt.stray_seen = 1'b0;
				end
				C_EOT: begin
					res.event_res = EV_EOT;
					nxt.stray_seen = 1'b0;
				end
				C_ACK: begin
					res.event_res = EV_ACK;
					nxt.stray_seen = 1'b0;
				end
				C_NAK: begin
					res.event_res = EV_NAK;
					nxt.stray_seen = 1'b0;
				end
				default: begin
					nxt.stray_seen = 1'b1;
				end
			endcase
		end else if (rx_byte == C_STX) begin
			nxt.running_sum = '0;
			nxt.phase = PH_BODY;
		end else begin
			unique case (cur.phase)
				PH_BODY: begin
					nxt.running_sum = cur.running_sum + rx_byte;
					if (rx_byte == C_ETX || rx_byte == C_ETB) begin
						nxt.phase = PH_CK1;
					end
				end
				PH_CK1: begin
					if (rx_byte == C_LF) begin
						finish = 1'b1;
					end else begin
						nxt.first_hex_char = rx_byte;
						nxt.phase = PH_CK2;
					end
				end
				PH_CK2: begin
					if (rx_byte == C_LF) begin
						finish = 1'b1;
					end else begin
						nxt.phase = (hi_ok && lo_ok) ? PH_WOK : PH_WBAD;
					end
				end
				default: begin
					if (rx_byte == C_LF) begin
						finish = 1'b1;
						good = cur.phase == PH_WOK;
					end
				end
			endcase
		end
		if (finish) begin
			if (cur.stray_seen) begin
				res.event_res = EV_FMT;
				res.reply = RP_NAK;
			end else if (good) begin
				res.event_res = EV_GOOD;
				res.reply = RP_ACK;
			end else begin
				res.event_res = EV_BAD;
				res.reply = RP_NAK;
			end
			res.frame_sum = cur.running_sum;
			nxt.stray_seen = 1'b0;
			nxt.phase = PH_IDLE;
		end
	end

endmodule
`default_nettype wire
